### rtl/hrlr_pkg.sv
// Shared types, codes and helpers of the history ring log reader.
`default_nettype none
package hrlr_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [4:0] REC_BASE_LEN = 5'd10;
  localparam logic [2:0] MASK_PRES    = 3'h4;
  localparam logic [2:0] MASK_HUM     = 3'h2;
  localparam logic [2:0] MASK_TEMP    = 3'h1;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_NODATA = 2'd2
  } kind_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] stamp;
    logic [2:0]  present_mask;
    logic [15:0] humidity_value;
    logic [31:0] start_entry;
    logic [4:0]  batch_count;
  } in_word_t;

  typedef struct packed {
    kind_e       result_kind;
    logic        not_wrapped;
    logic [4:0]  record_length;
    logic [31:0] entry_number;
    logic [31:0] elapsed_seconds;
    logic [2:0]  record_mask;
    logic [15:0] record_humidity;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [2:0]  mask;
    logic [15:0] humidity;
  } rec_t;

  typedef struct packed {
    logic append;
    logic rd_start;
    logic check;
    logic nodata;
    logic read;
    logic prime;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic reject;
    logic stop;
  } status_t;

  function automatic logic [4:0] rec_len(input logic [2:0] m);
    logic [1:0] n;
    n = 2'((m & MASK_TEMP) != 3'h0) + 2'((m & MASK_HUM) != 3'h0)
      + 2'((m & MASK_PRES) != 3'h0);
    return REC_BASE_LEN + {2'b00, n, 1'b0};
  endfunction

endpackage
`default_nettype wire

### rtl/hrlr_rem_unit.sv
// Remainder of a 32-bit value by the log depth, found by reciprocal multiplication.
`default_nettype none
module hrlr_rem_unit #(
  parameter int unsigned LOG_DEPTH = 128
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [31:0]                  value_i,
  output logic                              done_o,
  output logic [$clog2(LOG_DEPTH)-1:0]      rem_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam logic [AW:0] DIV   = (AW + 1)'(LOG_DEPTH);
  localparam logic [31:0] DIV_W = 32'(LOG_DEPTH);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(LOG_DEPTH));

  logic [31:0] x_q;
  logic [31:0] quot_q, quot_d;
  logic [AW:0] part_q, part_d;
  logic        mul_q, back_q, done_q;
  logic [63:0] prod;
  logic [31:0] back;

  // The quotient estimate is low by at most one, so the partial remainder is below twice
  // the depth and a single subtraction finishes it.
  always_comb begin
    prod   = {32'h0, x_q} * {32'h0, RECIP};
    quot_d = prod[63:32];
    back   = x_q - quot_q * DIV_W;
    part_d = back[AW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      back_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      back_q <= mul_q;
      done_q <= back_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= value_i;
    end
    if (mul_q) begin
      quot_q <= quot_d;
    end
    if (back_q) begin
      part_q <= part_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = (part_q >= DIV) ? AW'(part_q - DIV) : part_q[AW-1:0];

endmodule
`default_nettype wire

### rtl/hrlr_ctrl.sv
// Controller state machine that sequences appends and history reads.
`default_nettype none
module hrlr_ctrl import hrlr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    operation_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CHECK,
    ST_PRIME,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (operation_i == OP_APPEND) begin
            cmd.append = 1'b1;
          end else begin
            cmd.rd_start = 1'b1;
            state_d      = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (status_i.mod_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (status_i.reject) begin
          cmd.nodata = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd.read = 1'b1;
          state_d  = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        cmd.read  = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status_i.stop) begin
          state_d = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
          cmd.read    = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

### rtl/hrlr_datapath.sv
// Datapath: record store, ring indices, read walk registers and result word.
`default_nettype none
module hrlr_datapath import hrlr_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 128,
  parameter int unsigned MAX_BATCH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire in_word_t    in_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output status_t          status_o,
  output logic             result_valid_o,
  output out_word_t        result_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned UW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_BATCH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
  localparam logic [UW-1:0] FULL      = UW'(LOG_DEPTH);

  rec_t mem [LOG_DEPTH];
  rec_t rd_data_q, cur_q;

  logic [AW-1:0] wi_q, wi_next, slot_q, slot_next, ptr_q, ptr_next;
  logic [UW-1:0] used_q, used_d;
  logic          wrapped_q, wrapped_d;
  logic [31:0]   ref_q, entry_q;
  logic [CW-1:0] remain_q, count_d;
  logic          mod_done;
  logic [AW-1:0] mod_rem;
  logic          valid_q, valid_d;
  out_word_t     res_q, res_d;

  hrlr_rem_unit #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.rd_start),
    .value_i(in_i.start_entry - 32'd1),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  always_comb begin
    wi_next   = (wi_q == LAST_SLOT) ? '0 : wi_q + 1'b1;
    slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
    ptr_next  = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
    used_d    = (used_q == FULL) ? used_q : used_q + 1'b1;
    wrapped_d = wrapped_q | (used_d == FULL);
    if (32'(in_i.batch_count) > MAX_BATCH) begin
      count_d = CW'(MAX_BATCH);
    end else begin
      count_d = CW'(in_i.batch_count);
    end
  end

  assign status_o.mod_done = mod_done;
  assign status_o.reject   = (remain_q == '0) || (!wrapped_q && (slot_q >= wi_q));
  assign status_o.stop     = (remain_q == CW'(1))
                           || (!wrapped_q && (({1'b0, slot_q} + 1'b1) >= {1'b0, wi_q}))
                           || (wrapped_q && (cur_q.stamp > rd_data_q.stamp));

  always_comb begin
    res_d   = '0;
    valid_d = cmd_i.append | cmd_i.nodata | cmd_i.emit;
    if (cmd_i.append) begin
      res_d.result_kind = KIND_ACK;
      res_d.not_wrapped = ~wrapped_d;
      res_d.last        = 1'b1;
    end else if (cmd_i.nodata) begin
      res_d.result_kind = KIND_NODATA;
      res_d.last        = 1'b1;
    end else begin
      res_d.result_kind     = KIND_RECORD;
      res_d.record_length   = rec_len(cur_q.mask);
      res_d.entry_number    = entry_q;
      res_d.elapsed_seconds = cur_q.stamp - ref_q;
      res_d.record_mask     = cur_q.mask;
      res_d.record_humidity = ((cur_q.mask & MASK_HUM) != 3'h0) ? cur_q.humidity : 16'h0;
      res_d.last            = status_o.stop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[wi_q] <= '{stamp: in_i.stamp, mask: in_i.present_mask,
                     humidity: in_i.humidity_value};
    end
    if (cmd_i.read) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      used_q    <= '0;
      wrapped_q <= 1'b0;
      ref_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        ref_q <= cfg_wdata_i;
      end
      if (cmd_i.append) begin
        wi_q      <= wi_next;
        used_q    <= used_d;
        wrapped_q <= wrapped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      res_q <= res_d;
    end
    if (cmd_i.rd_start) begin
      entry_q  <= in_i.start_entry;
      remain_q <= count_d;
    end
    if (mod_done) begin
      slot_q <= mod_rem;
      ptr_q  <= mod_rem;
    end else if (cmd_i.read) begin
      ptr_q <= ptr_next;
    end
    if (cmd_i.prime) begin
      cur_q <= rd_data_q;
    end
    if (cmd_i.advance) begin
      cur_q    <= rd_data_q;
      slot_q   <= slot_next;
      entry_q  <= entry_q + 32'd1;
      remain_q <= remain_q - 1'b1;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire

### rtl/history_ring_log_reader_unit.sv
// Top level of the history ring log reader: controller, datapath and checks.
`default_nettype none
// A word is accepted when start_i is high and busy_o is low. An append's acknowledge word
// appears on the next cycle and busy_o stays low, so a new word can follow at once. A read
// holds busy_o high while the start slot is found by the remainder unit (a reciprocal
// multiplication, a multiply-back and a final correction), then while the start is checked
// and, unless the read is refused, the first record is fetched from the single read port of
// the record store, then while one record is sent per cycle. Each result word is shown for
// exactly one cycle with result_valid_o high; the receiver cannot hold it off. The reference
// time may be written at any time the block is idle.
module history_ring_log_reader_unit import hrlr_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 128,
  parameter int unsigned MAX_BATCH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire in_word_t    in_i,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  output logic             result_valid_o,
  output out_word_t        result_o
);

  cmd_t    cmd;
  status_t status;

  hrlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(in_i.operation),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  hrlr_datapath #(
    .LOG_DEPTH(LOG_DEPTH),
    .MAX_BATCH(MAX_BATCH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_i          (in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (status),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

`ifndef SYNTHESIS
  a_append_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.operation == OP_APPEND
    |=> result_valid_o && result_o.result_kind == KIND_ACK && result_o.last)
    else $error("append was not acknowledged on the next cycle");

  a_read_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && result_o.last)
    else $error("read finished without a final word");

  a_more_records_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.result_kind == KIND_RECORD && !result_o.last |-> busy_o)
    else $error("block idle while a read batch is still open");
`endif

endmodule
`default_nettype wire

### bench/tb_history_ring_log_reader_unit.sv
// Self-checking testbench of the history ring log reader: directed and random words.
module tb_history_ring_log_reader_unit;
  import hrlr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LOG_DEPTH   = 128;
  localparam int unsigned MAX_BATCH   = 16;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_word_t    in_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  out_word_t   result_o;

  history_ring_log_reader_unit #(
    .LOG_DEPTH(LOG_DEPTH),
    .MAX_BATCH(MAX_BATCH)
  ) dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .in_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .result_valid_o,
    .result_o
  );

  always #5 clk_i = ~clk_i;

  rec_t        log_mem [LOG_DEPTH];
  int unsigned log_wr_slot = 0;
  int unsigned log_used = 0;
  logic        log_wrapped = 1'b0;
  logic [31:0] ref_time_q = '0;

  out_word_t   pending_words[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [31:0] sensor_clock;

  function automatic void predict_history_words(input in_word_t w);
    out_word_t   r;
    logic [31:0] entry;
    logic [31:0] stamp_now;
    int unsigned slot;
    int unsigned nxt;
    int unsigned count;
    int unsigned tail;
    r = '0;
    if (w.operation == OP_APPEND) begin
      log_mem[log_wr_slot] = '{stamp: w.stamp, mask: w.present_mask,
                               humidity: w.humidity_value};
      if (log_used < LOG_DEPTH) log_used++;
      log_wr_slot = (log_wr_slot + 1) % LOG_DEPTH;
      if (log_used == LOG_DEPTH) log_wrapped = 1'b1;
      r.result_kind = KIND_ACK;
      r.not_wrapped = ~log_wrapped;
      r.last = 1'b1;
      pending_words.push_back(r);
    end else begin
      entry = w.start_entry;
      slot = (entry - 32'd1) % LOG_DEPTH;
      count = (w.batch_count > MAX_BATCH) ? MAX_BATCH : w.batch_count;
      if (count == 0 || (slot >= log_wr_slot && !log_wrapped)) begin
        r.result_kind = KIND_NODATA;
        r.last = 1'b1;
        pending_words.push_back(r);
      end else begin
        for (int unsigned i = 0; i < count; i++) begin
          stamp_now = log_mem[slot].stamp;
          r = '0;
          r.result_kind = KIND_RECORD;
          r.record_mask = log_mem[slot].mask;
          r.record_length = REC_BASE_LEN + 5'(2 * $countones(log_mem[slot].mask));
          r.entry_number = entry;
          r.elapsed_seconds = stamp_now - ref_time_q;
          r.record_humidity = ((log_mem[slot].mask & MASK_HUM) != 3'h0)
                              ? log_mem[slot].humidity : 16'h0;
          pending_words.push_back(r);
          entry++;
          if (slot + 1 >= log_wr_slot && !log_wrapped) break;
          nxt = (slot + 1) % LOG_DEPTH;
          if (log_wrapped && stamp_now > log_mem[nxt].stamp) break;
          slot = nxt;
        end
        tail = pending_words.size() - 1;
        pending_words[tail].last = 1'b1;
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, result_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result_o.result_kind));
        check_field("not_wrapped", 32'(want.not_wrapped), 32'(result_o.not_wrapped));
        check_field("record_length", 32'(want.record_length), 32'(result_o.record_length));
        check_field("entry_number", want.entry_number, result_o.entry_number);
        check_field("elapsed_seconds", want.elapsed_seconds, result_o.elapsed_seconds);
        check_field("record_mask", 32'(want.record_mask), 32'(result_o.record_mask));
        check_field("record_humidity", 32'(want.record_humidity),
                    32'(result_o.record_humidity));
        check_field("last", 32'(want.last), 32'(result_o.last));
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && busy_o === 1'b0) || result_valid_o === 1'b1 || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic in_word_t append_word(input logic [31:0] stamp, input logic [2:0] mask,
                                           input logic [15:0] hum);
    in_word_t w;
    w = '{operation: OP_APPEND, stamp: stamp, present_mask: mask, humidity_value: hum,
          start_entry: $urandom(), batch_count: 5'($urandom())};
    return w;
  endfunction

  function automatic in_word_t read_word(input logic [31:0] start, input logic [4:0] count);
    in_word_t w;
    w = '{operation: OP_READ, stamp: $urandom(), present_mask: 3'($urandom()),
          humidity_value: 16'($urandom()), start_entry: start, batch_count: count};
    return w;
  endfunction

  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 9) == 0) return $urandom();
    sensor_clock += 32'($urandom_range(1, 900));
    return sensor_clock;
  endfunction

  function automatic in_word_t random_read();
    logic [31:0] start;
    logic [4:0]  count;
    int unsigned slot;
    if ($urandom_range(0, 4) == 0 || (!log_wrapped && log_wr_slot == 0)) begin
      start = $urandom();
    end else begin
      slot = log_wrapped ? $urandom_range(0, LOG_DEPTH - 1) : $urandom_range(0, log_wr_slot - 1);
      start = 32'((($urandom() << 7) | slot) + 1);
    end
    count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(1, MAX_BATCH));
    return read_word(start, count);
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(4, 20);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i <= w;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_history_words(w);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_words.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reference_time(input logic [31:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    ref_time_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random(input int unsigned items, input int unsigned append_pct);
    for (int unsigned n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < append_pct && (log_wrapped || log_used < LOG_DEPTH - 8))
        send_word(append_word(next_stamp(), 3'($urandom()), 16'($urandom())));
      else
        send_word(random_read());
    end
  endtask

  task automatic test_empty_store();
    send_word(read_word(32'd1, 5'd16));
    send_word(read_word(32'd0, 5'd1));
    send_word(read_word(32'd5, 5'd0));
  endtask

  task automatic test_field_extremes();
    send_word(append_word(32'h0000_0000, 3'd0, 16'h0000));
    send_word(append_word(32'hFFFF_FFFF, 3'd7, 16'hFFFF));
    send_word(append_word(32'd5, MASK_TEMP, 16'hFFFF));
    send_word(append_word(32'd6, MASK_HUM, 16'h1234));
    send_word(append_word(32'd7, MASK_PRES, 16'hA5A5));
    send_word(append_word(32'd8, 3'd3, 16'h5A5A));
    send_word(append_word(32'd9, 3'd5, 16'hFFFF));
    send_word(append_word(32'd10, 3'd6, 16'h8001));
    send_word(read_word(32'd1, 5'd16));
    send_word(read_word(32'd8, 5'd1));
    send_word(read_word(32'd9, 5'd4));
    send_word(read_word(32'd3, 5'd0));
    send_word(read_word(32'd2, 5'd31));
    send_word(read_word(32'h8000_0001, 5'd3));
    send_word(read_word(32'hFFFF_FFFF, 5'd2));
  endtask

  task automatic test_reference_time();
    write_reference_time(32'hFFFF_FFFF);
    send_word(read_word(32'd1, 5'd8));
    write_reference_time(32'h8000_0000);
    send_word(read_word(32'd1, 5'd8));
    write_reference_time($urandom());
    send_word(read_word(32'd1, 5'd8));
    write_reference_time(32'h0000_0000);
    send_word(read_word(32'd1, 5'd8));
  endtask

  task automatic test_random_before_wrap();
    send_random(80, 35);
  endtask

  task automatic test_wrap_and_overflow();
    while (!log_wrapped) begin
      if ($urandom_range(0, 9) == 0)
        send_word(random_read());
      else
        send_word(append_word(next_stamp(), 3'($urandom()), 16'($urandom())));
    end
    send_word(append_word(next_stamp(), 3'($urandom()), 16'($urandom())));
    send_word(read_word(32'hFFFF_FFFF, 5'd16));
    send_word(read_word(32'h0000_0000, 5'd16));
    send_word(read_word(32'(log_wr_slot + 1), 5'd16));
  endtask

  task automatic test_random_after_wrap();
    write_reference_time($urandom());
    send_random(40, 40);
    write_reference_time(32'hFFFF_FFFF);
    send_random(40, 40);
    write_reference_time(32'h0000_0000);
    send_random(40, 40);
  endtask

  initial begin
    sensor_clock = $urandom_range(0, 32'h0FFF_FFFF);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_store();
    test_field_extremes();
    test_reference_time();
    test_random_before_wrap();
    test_wrap_and_overflow();
    test_random_after_wrap();
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hrlr_pkg.sv
rtl/hrlr_rem_unit.sv
rtl/hrlr_ctrl.sv
rtl/hrlr_datapath.sv
rtl/history_ring_log_reader_unit.sv
bench/tb_history_ring_log_reader_unit.sv
